// File: sv/qstm_pkg.sv
// Shared widths, constants and beat types for the quaternion TRS to matrix pipeline.
package qstm_pkg;

   localparam int DataWidth   = 32;
   localparam int MagWidth    = 30;
   localparam int SqWidth     = 2 * MagWidth;
   localparam int SumWidth    = SqWidth + 2;
   localparam int RootWidth   = SumWidth / 2;
   localparam int RemWidth    = RootWidth + 2;
   localparam int SqrtSteps   = RootWidth;
   localparam int QuotWidth   = 31;
   localparam int DivSteps    = QuotWidth;
   localparam int QWidth      = 32;
   localparam int ProdWidth   = 62;
   localparam int FacWidth    = 64;
   localparam int RndWidth    = 34;
   localparam int ScProdWidth = RndWidth + DataWidth;
   localparam int ScOutWidth  = 36;
   localparam int FracShift   = 30;
   localparam int TargetMsb   = 29;
   localparam int ShiftWidth  = 5;
   localparam int NormStages  = 5;
   localparam int MatStages   = 6;
   localparam int TrsWidth    = 6 * DataWidth;

   localparam logic signed [QWidth-1:0]   OneQ30 = 32'sh4000_0000;
   localparam logic signed [FacWidth-1:0] OneQ60 = 64'sh1000_0000_0000_0000;

   typedef logic signed [DataWidth-1:0] word_type;
   typedef logic signed [QWidth-1:0]    q_type;

   typedef struct packed {
      word_type trans_x;
      word_type trans_y;
      word_type trans_z;
      word_type quat_x;
      word_type quat_y;
      word_type quat_z;
      word_type quat_w;
      word_type scale_x;
      word_type scale_y;
      word_type scale_z;
   } qstm_req_type;

   typedef struct packed {
      word_type col0_row0;
      word_type col0_row1;
      word_type col0_row2;
      word_type col1_row0;
      word_type col1_row1;
      word_type col1_row2;
      word_type col2_row0;
      word_type col2_row1;
      word_type col2_row2;
      word_type col3_row0;
      word_type col3_row1;
      word_type col3_row2;
   } qstm_rsp_type;

endpackage

// File: sv/qstm_norm.sv
// Quaternion magnitude, common exponent shift and sum of squares, five stages.
module qstm_norm import qstm_pkg::*; #(
   parameter int AuxWidth = TrsWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  word_type [3:0]               in_quat,
   input  logic [AuxWidth-1:0]          in_aux,
   output logic                         out_valid,
   output logic [3:0][MagWidth-1:0]     out_mag,
   output logic [SumWidth-1:0]          out_sum,
   output logic [3:0]                   out_neg,
   output logic                         out_zero,
   output logic [AuxWidth-1:0]          out_aux
);

   logic [NormStages-1:0] valid_ff;

   logic [3:0][DataWidth-1:0] mag1_in, mag1_ff, mag2_ff;
   logic [3:0]                neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [AuxWidth-1:0]       aux1_ff, aux2_ff, aux3_ff, aux4_ff, aux5_ff;
   logic [DataWidth-1:0]      or_bits;
   logic [ShiftWidth-1:0]     pos;
   logic                      zero2_in, zero2_ff, zero3_ff, zero4_ff, zero5_ff;
   logic                      right2_in, right2_ff;
   logic [ShiftWidth-1:0]     amt2_in, amt2_ff;
   logic [3:0][MagWidth-1:0]  mag3_in, mag3_ff, mag4_ff, mag5_ff;
   logic [3:0][SqWidth-1:0]   sq4_in, sq4_ff;
   logic [SumWidth-1:0]       sum5_in, sum5_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag1_in[i] = in_quat[i][DataWidth-1] ? DataWidth'(-$signed(in_quat[i]))
                                              : DataWidth'(in_quat[i]);
      end
   end

   always_comb begin
      or_bits = mag1_ff[0] | mag1_ff[1] | mag1_ff[2] | mag1_ff[3];
      pos = '0;
      for (int k = 0; k < DataWidth; k++) begin
         if (or_bits[k]) begin
            pos = ShiftWidth'(k);
         end
      end
      zero2_in  = (or_bits == '0);
      right2_in = (pos > ShiftWidth'(TargetMsb));
      amt2_in   = right2_in ? ShiftWidth'(pos - ShiftWidth'(TargetMsb))
                            : ShiftWidth'(ShiftWidth'(TargetMsb) - pos);
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag3_in[i] = right2_ff ? MagWidth'(mag2_ff[i] >> amt2_ff)
                                : MagWidth'(mag2_ff[i] << amt2_ff);
         sq4_in[i]  = SqWidth'(mag3_ff[i]) * SqWidth'(mag3_ff[i]);
      end
      sum5_in = SumWidth'(sq4_ff[0]) + SumWidth'(sq4_ff[1])
              + SumWidth'(sq4_ff[2]) + SumWidth'(sq4_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NormStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff   <= mag1_in;
         neg1_ff   <= {in_quat[3][DataWidth-1], in_quat[2][DataWidth-1],
                       in_quat[1][DataWidth-1], in_quat[0][DataWidth-1]};
         aux1_ff   <= in_aux;
         mag2_ff   <= mag1_ff;
         neg2_ff   <= neg1_ff;
         aux2_ff   <= aux1_ff;
         zero2_ff  <= zero2_in;
         right2_ff <= right2_in;
         amt2_ff   <= amt2_in;
         mag3_ff   <= mag3_in;
         neg3_ff   <= neg2_ff;
         zero3_ff  <= zero2_ff;
         aux3_ff   <= aux2_ff;
         sq4_ff    <= sq4_in;
         mag4_ff   <= mag3_ff;
         neg4_ff   <= neg3_ff;
         zero4_ff  <= zero3_ff;
         aux4_ff   <= aux3_ff;
         sum5_ff   <= sum5_in;
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
         zero5_ff  <= zero4_ff;
         aux5_ff   <= aux4_ff;
      end
   end

   assign out_valid = valid_ff[NormStages-1];
   assign out_mag   = mag5_ff;
   assign out_sum   = sum5_ff;
   assign out_neg   = neg5_ff;
   assign out_zero  = zero5_ff;
   assign out_aux   = aux5_ff;

endmodule

// File: sv/qstm_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module qstm_isqrt import qstm_pkg::*; #(
   parameter int AuxWidth = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [SumWidth-1:0]   in_sum,
   input  logic [AuxWidth-1:0]   in_aux,
   output logic                  out_valid,
   output logic [RootWidth-1:0]  out_root,
   output logic [AuxWidth-1:0]   out_aux
);

   logic [SqrtSteps-1:0] valid_ff;
   logic [SumWidth-1:0]  x_ff    [SqrtSteps-1];
   logic [RemWidth-1:0]  rem_ff  [SqrtSteps-1];
   logic [RootWidth-1:0] root_ff [SqrtSteps];
   logic [AuxWidth-1:0]  aux_ff  [SqrtSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[SqrtSteps-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      logic [SumWidth-1:0]  x_pre;
      logic [RemWidth-1:0]  rem_pre;
      logic [RootWidth-1:0] root_pre;
      logic [AuxWidth-1:0]  aux_pre;
      logic [RemWidth+1:0]  cur;
      logic [RemWidth+1:0]  trial;
      logic [RemWidth-1:0]  rem_in;
      logic [RootWidth-1:0] root_in;

      if (s == 0) begin : g_first
         assign x_pre    = in_sum;
         assign rem_pre  = '0;
         assign root_pre = '0;
         assign aux_pre  = in_aux;
      end else begin : g_next
         assign x_pre    = x_ff[s-1];
         assign rem_pre  = rem_ff[s-1];
         assign root_pre = root_ff[s-1];
         assign aux_pre  = aux_ff[s-1];
      end

      always_comb begin
         cur   = {rem_pre, x_pre[2*(SqrtSteps-1-s)+1 -: 2]};
         trial = (RemWidth+2)'({root_pre, 2'b01});
         if (cur >= trial) begin
            rem_in  = RemWidth'(cur - trial);
            root_in = {root_pre[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = RemWidth'(cur);
            root_in = {root_pre[RootWidth-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[s] <= root_in;
            aux_ff[s]  <= aux_pre;
         end
      end

      if (s < SqrtSteps - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               x_ff[s]   <= x_pre;
               rem_ff[s] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[SqrtSteps-1];
   assign out_root  = root_ff[SqrtSteps-1];
   assign out_aux   = aux_ff[SqrtSteps-1];

endmodule

// File: sv/qstm_div.sv
// Four-lane pipelined restoring divider, one quotient bit per stage.
module qstm_div import qstm_pkg::*; #(
   parameter int AuxWidth = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [3:0][MagWidth-1:0]    in_mag,
   input  logic [RootWidth-1:0]        in_root,
   input  logic [AuxWidth-1:0]         in_aux,
   output logic                        out_valid,
   output logic [3:0][QuotWidth-1:0]   out_quot,
   output logic [AuxWidth-1:0]         out_aux
);

   logic [DivSteps-1:0]              valid_ff;
   logic [RootWidth-1:0]             d_ff    [DivSteps-1];
   logic [3:0][RootWidth-1:0]        rem_ff  [DivSteps-1];
   logic [3:0][QuotWidth-1:0]        quot_ff [DivSteps];
   logic [AuxWidth-1:0]              aux_ff  [DivSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DivSteps-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      logic [RootWidth-1:0]        d_pre;
      logic [3:0][RootWidth:0]     cur;
      logic [3:0][QuotWidth-1:0]   quot_pre;
      logic [AuxWidth-1:0]         aux_pre;
      logic [3:0][RootWidth-1:0]   rem_in;
      logic [3:0][QuotWidth-1:0]   quot_in;

      if (s == 0) begin : g_first
         assign d_pre    = in_root;
         assign quot_pre = '0;
         assign aux_pre  = in_aux;
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign cur[i] = (RootWidth+1)'(in_mag[i]);
         end
      end else begin : g_next
         assign d_pre    = d_ff[s-1];
         assign quot_pre = quot_ff[s-1];
         assign aux_pre  = aux_ff[s-1];
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign cur[i] = {rem_ff[s-1][i], 1'b0};
         end
      end

      always_comb begin
         for (int i = 0; i < 4; i++) begin
            if (cur[i] >= (RootWidth+1)'(d_pre)) begin
               rem_in[i]  = RootWidth'(cur[i] - (RootWidth+1)'(d_pre));
               quot_in[i] = {quot_pre[i][QuotWidth-2:0], 1'b1};
            end else begin
               rem_in[i]  = RootWidth'(cur[i]);
               quot_in[i] = {quot_pre[i][QuotWidth-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quot_ff[s] <= quot_in;
            aux_ff[s]  <= aux_pre;
         end
      end

      if (s < DivSteps - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               d_ff[s]   <= d_pre;
               rem_ff[s] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_quot  = quot_ff[DivSteps-1];
   assign out_aux   = aux_ff[DivSteps-1];

endmodule

// File: sv/qstm_matrix.sv
// Rotation matrix factors, rounding, scaling and saturation, six stages.
module qstm_matrix import qstm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [3:0][QuotWidth-1:0]  in_quot,
   input  logic [3:0]                 in_neg,
   input  logic                       in_zero,
   input  word_type [2:0]             in_scale,
   input  word_type [2:0]             in_trans,
   output logic                       out_valid,
   output word_type [8:0]             out_elem,
   output word_type [2:0]             out_trans
);

   localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, XW = 6, YW = 7, ZW = 8;
   localparam int PA [9] = '{0, 1, 2, 0, 0, 1, 0, 1, 2};
   localparam int PB [9] = '{0, 1, 2, 1, 2, 2, 3, 3, 3};
   localparam int ScaleOf [9] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
   localparam logic signed [ScOutWidth-1:0] SatMax = ScOutWidth'(32'sh7FFF_FFFF);
   localparam logic signed [ScOutWidth-1:0] SatMin = -SatMax - ScOutWidth'(1);
   localparam logic signed [FacWidth-1:0]   HalfF = FacWidth'(1) <<< (FracShift - 1);
   localparam logic signed [ScProdWidth-1:0] HalfS = ScProdWidth'(1) <<< (FracShift - 1);

   logic [MatStages-1:0] valid_ff;

   q_type                          q1_in   [4];
   q_type                          q1_ff   [4];
   logic signed [ProdWidth-1:0]    prod2_in [9];
   logic signed [ProdWidth-1:0]    prod2_ff [9];
   logic signed [FacWidth-1:0]     fac3_in [9];
   logic signed [FacWidth-1:0]     fac3_ff [9];
   logic signed [FacWidth-1:0]     fsum4   [9];
   logic signed [RndWidth-1:0]     rnd4_in [9];
   logic signed [RndWidth-1:0]     rnd4_ff [9];
   logic signed [ScProdWidth-1:0]  sp5_in  [9];
   logic signed [ScProdWidth-1:0]  sp5_ff  [9];
   logic signed [ScProdWidth-1:0]  ssum6   [9];
   logic signed [ScOutWidth-1:0]   sr6     [9];
   word_type                       el6_in  [9];
   word_type                       el6_ff  [9];
   word_type                       sc_ff   [4][3];
   word_type                       tr_ff   [MatStages][3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q1_in[i] = in_neg[i] ? -$signed(QWidth'(in_quot[i])) : $signed(QWidth'(in_quot[i]));
      end
      if (in_zero) begin
         q1_in[0] = '0;
         q1_in[1] = '0;
         q1_in[2] = '0;
         q1_in[3] = OneQ30;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod2_in[k] = q1_ff[PA[k]] * q1_ff[PB[k]];
      end
   end

   always_comb begin
      fac3_in[0] = OneQ60 - ((FacWidth'(prod2_ff[YY]) + FacWidth'(prod2_ff[ZZ])) <<< 1);
      fac3_in[1] = (FacWidth'(prod2_ff[XY]) + FacWidth'(prod2_ff[ZW])) <<< 1;
      fac3_in[2] = (FacWidth'(prod2_ff[XZ]) - FacWidth'(prod2_ff[YW])) <<< 1;
      fac3_in[3] = (FacWidth'(prod2_ff[XY]) - FacWidth'(prod2_ff[ZW])) <<< 1;
      fac3_in[4] = OneQ60 - ((FacWidth'(prod2_ff[XX]) + FacWidth'(prod2_ff[ZZ])) <<< 1);
      fac3_in[5] = (FacWidth'(prod2_ff[YZ]) + FacWidth'(prod2_ff[XW])) <<< 1;
      fac3_in[6] = (FacWidth'(prod2_ff[XZ]) + FacWidth'(prod2_ff[YW])) <<< 1;
      fac3_in[7] = (FacWidth'(prod2_ff[YZ]) - FacWidth'(prod2_ff[XW])) <<< 1;
      fac3_in[8] = OneQ60 - ((FacWidth'(prod2_ff[XX]) + FacWidth'(prod2_ff[YY])) <<< 1);
   end

   // Rounding to nearest with ties away from zero: negative values take a bias one smaller.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         fsum4[k]   = fac3_ff[k] + (fac3_ff[k][FacWidth-1] ? HalfF - FacWidth'(1) : HalfF);
         rnd4_in[k] = RndWidth'(fsum4[k] >>> FracShift);
         sp5_in[k]  = rnd4_ff[k] * sc_ff[3][ScaleOf[k]];
         ssum6[k]   = sp5_ff[k]
                    + (sp5_ff[k][ScProdWidth-1] ? HalfS - ScProdWidth'(1) : HalfS);
         sr6[k]     = ScOutWidth'(ssum6[k] >>> FracShift);
         if (sr6[k] > SatMax) begin
            el6_in[k] = DataWidth'(SatMax);
         end else if (sr6[k] < SatMin) begin
            el6_in[k] = DataWidth'(SatMin);
         end else begin
            el6_in[k] = DataWidth'(sr6[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[MatStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff    <= q1_in;
         prod2_ff <= prod2_in;
         fac3_ff  <= fac3_in;
         rnd4_ff  <= rnd4_in;
         sp5_ff   <= sp5_in;
         el6_ff   <= el6_in;
         for (int j = 0; j < 3; j++) begin
            sc_ff[0][j] <= in_scale[j];
            tr_ff[0][j] <= in_trans[j];
         end
         for (int s = 1; s < 4; s++) begin
            sc_ff[s] <= sc_ff[s-1];
         end
         for (int s = 1; s < MatStages; s++) begin
            tr_ff[s] <= tr_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         out_elem[k] = el6_ff[k];
      end
      for (int j = 0; j < 3; j++) begin
         out_trans[j] = tr_ff[MatStages-1][j];
      end
   end

   assign out_valid = valid_ff[MatStages-1];

endmodule

// File: sv/quat_scale_translate_to_matrix.sv
// Top level: quaternion, scale and translation beats in, 4x4 matrix columns out.
// Takes one transform beat per clock unless stalled; its matrix beat comes out after 5 stages
// of magnitude, shift and sum of squares, 31 square root stages, 31 divider stages (one bit
// each) and 6 stages of products, rounding, scaling and saturation. The whole pipeline holds
// while a finished beat on the result side is stalled, and req_stall is raised in those
// cycles only. A quaternion of zero length is treated as the identity rotation.
module quat_scale_translate_to_matrix import qstm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  qstm_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output qstm_rsp_type rsp_data
);

   localparam int SqrtAuxWidth = TrsWidth + 5 + 4 * MagWidth;
   localparam int DivAuxWidth  = TrsWidth + 5;

   logic                         adv;
   logic [TrsWidth-1:0]          req_trs;
   logic                         norm_valid;
   logic [3:0][MagWidth-1:0]     norm_mag;
   logic [SumWidth-1:0]          norm_sum;
   logic [3:0]                   norm_neg;
   logic                         norm_zero;
   logic [TrsWidth-1:0]          norm_trs;
   logic                         sqrt_valid;
   logic [RootWidth-1:0]         sqrt_root;
   logic [SqrtAuxWidth-1:0]      sqrt_aux;
   logic                         div_valid;
   logic [3:0][QuotWidth-1:0]    div_quot;
   logic [DivAuxWidth-1:0]       div_aux;
   word_type [8:0]               mat_elem;
   word_type [2:0]               mat_trans;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign req_trs   = {req_data.scale_z, req_data.scale_y, req_data.scale_x,
                       req_data.trans_z, req_data.trans_y, req_data.trans_x};

   qstm_norm #(.AuxWidth(TrsWidth)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_quat   ({req_data.quat_w, req_data.quat_z, req_data.quat_y, req_data.quat_x}),
      .in_aux    (req_trs),
      .out_valid (norm_valid),
      .out_mag   (norm_mag),
      .out_sum   (norm_sum),
      .out_neg   (norm_neg),
      .out_zero  (norm_zero),
      .out_aux   (norm_trs)
   );

   qstm_isqrt #(.AuxWidth(SqrtAuxWidth)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (norm_valid),
      .in_sum    (norm_sum),
      .in_aux    ({norm_trs, norm_neg, norm_zero, norm_mag}),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_aux   (sqrt_aux)
   );

   qstm_div #(.AuxWidth(DivAuxWidth)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sqrt_valid),
      .in_mag    (sqrt_aux[4*MagWidth-1:0]),
      .in_root   (sqrt_root),
      .in_aux    (sqrt_aux[SqrtAuxWidth-1:4*MagWidth]),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_aux   (div_aux)
   );

   qstm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_quot   (div_quot),
      .in_neg    (div_aux[4:1]),
      .in_zero   (div_aux[0]),
      .in_scale  (div_aux[DivAuxWidth-1:5+3*DataWidth]),
      .in_trans  (div_aux[5+3*DataWidth-1:5]),
      .out_valid (rsp_valid),
      .out_elem  (mat_elem),
      .out_trans (mat_trans)
   );

   always_comb begin
      rsp_data.col0_row0 = mat_elem[0];
      rsp_data.col0_row1 = mat_elem[1];
      rsp_data.col0_row2 = mat_elem[2];
      rsp_data.col1_row0 = mat_elem[3];
      rsp_data.col1_row1 = mat_elem[4];
      rsp_data.col1_row2 = mat_elem[5];
      rsp_data.col2_row0 = mat_elem[6];
      rsp_data.col2_row1 = mat_elem[7];
      rsp_data.col2_row2 = mat_elem[8];
      rsp_data.col3_row0 = mat_trans[0];
      rsp_data.col3_row1 = mat_trans[1];
      rsp_data.col3_row2 = mat_trans[2];
   end

`ifndef SYNTHESIS
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("Input beat taken while a result beat is stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat valid straight after reset.");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("Input stalled although the result side is free.");
`endif

endmodule

// File: verif/quat_scale_translate_to_matrix_test.sv
// Self-checking testbench for the quaternion, scale and translation to matrix pipeline.
module quat_scale_translate_to_matrix_test import qstm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   qstm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   qstm_rsp_type rsp_data;

   qstm_req_type pending_transforms[$];
   qstm_rsp_type expected_matrices[$];
   int           idle_pct_req = 13;
   int           idle_pct_rsp = 85;
   int           mismatches = 0;
   int           beats_in = 0;
   int           beats_out = 0;
   int           zero_quats = 0;
   bit           req_taken = 1'b0;

   quat_scale_translate_to_matrix uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] round_to(input logic signed [63:0] v, input int sh);
      logic [63:0] m;
      m = abs64(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic word_type scaled_element(input logic signed [63:0] f60,
                                               input word_type sc);
      logic signed [63:0] f30;
      logic signed [63:0] p;
      logic signed [63:0] v;
      f30 = round_to(f60, 30);
      p = f30 * 64'(sc);
      v = round_to(p, 30);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return word_type'(v);
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic qstm_rsp_type matrix_of(input qstm_req_type t);
      logic signed [63:0] raw[4];
      logic signed [63:0] q[4];
      logic [63:0] a[4];
      logic [63:0] m;
      logic [63:0] s;
      logic [63:0] r;
      logic signed [63:0] x, y, z, w, xx, yy, zz, xy, xz, yz, xw, yw, zw;
      logic signed [63:0] one60;
      qstm_rsp_type o;
      raw[0] = 64'(t.quat_x); raw[1] = 64'(t.quat_y);
      raw[2] = 64'(t.quat_z); raw[3] = 64'(t.quat_w);
      m = 0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = abs64(raw[i]);
         if (a[i] > m) m = a[i];
      end
      if (m == 0) begin
         q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 64'sd1 << 30;
      end else begin
         while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 4; i++) a[i] >>= 1;
            m >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 4; i++) a[i] <<= 1;
            m <<= 1;
         end
         for (int i = 0; i < 4; i++) s += a[i] * a[i];
         r = root64(s);
         for (int i = 0; i < 4; i++) begin
            q[i] = $signed((a[i] << 30) / r);
            if (raw[i] < 0) q[i] = -q[i];
         end
      end
      x = q[0]; y = q[1]; z = q[2]; w = q[3];
      xx = x * x; yy = y * y; zz = z * z;
      xy = x * y; xz = x * z; yz = y * z;
      xw = x * w; yw = y * w; zw = z * w;
      one60 = 64'sd1 << 60;
      o.col0_row0 = scaled_element(one60 - 2 * (yy + zz), t.scale_x);
      o.col0_row1 = scaled_element(2 * (xy + zw), t.scale_x);
      o.col0_row2 = scaled_element(2 * (xz - yw), t.scale_x);
      o.col1_row0 = scaled_element(2 * (xy - zw), t.scale_y);
      o.col1_row1 = scaled_element(one60 - 2 * (xx + zz), t.scale_y);
      o.col1_row2 = scaled_element(2 * (yz + xw), t.scale_y);
      o.col2_row0 = scaled_element(2 * (xz + yw), t.scale_z);
      o.col2_row1 = scaled_element(2 * (yz - xw), t.scale_z);
      o.col2_row2 = scaled_element(one60 - 2 * (xx + yy), t.scale_z);
      o.col3_row0 = t.trans_x;
      o.col3_row1 = t.trans_y;
      o.col3_row2 = t.trans_z;
      return o;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: return word_type'($urandom);
         1: return word_type'($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
         2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         3: return word_type'($urandom_range(0, 7)) - 32'sd3;
         default: return word_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   // Driver: a new beat is presented once the previous one has been accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_transforms.size() > 0 && $urandom_range(0, 99) >= idle_pct_req) begin
               req_data <= pending_transforms.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct_rsp);
      end
   end

   // Monitor: predictions are made at acceptance and results checked in order.
   always @(posedge clock) begin
      qstm_rsp_type exp_m;
      req_taken = req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_matrices.push_back(matrix_of(req_data));
            beats_in++;
            if (req_data.quat_x == 0 && req_data.quat_y == 0 &&
                req_data.quat_z == 0 && req_data.quat_w == 0) zero_quats++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (expected_matrices.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result beat %p", rsp_data);
            end else begin
               exp_m = expected_matrices.pop_front();
               if (rsp_data !== exp_m) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch on beat %0d: expected %p, got %p",
                              beats_out, exp_m, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      qstm_req_type t;
      word_type edges[6];
      edges = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 32'sh0001_0000,
                -32'sh0001_0000, 32'sh1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      t = '0;
      t.scale_x = 32'sh0001_0000; t.scale_y = 32'sh0002_0000; t.scale_z = -32'sh0001_0000;
      pending_transforms.push_back(t);
      for (int i = 0; i < 6; i++) begin
         t.trans_x = edges[i]; t.trans_y = edges[(i + 1) % 6]; t.trans_z = edges[(i + 2) % 6];
         t.quat_x = edges[i]; t.quat_y = edges[(i + 3) % 6];
         t.quat_z = edges[(i + 4) % 6]; t.quat_w = edges[(i + 5) % 6];
         t.scale_x = edges[i]; t.scale_y = edges[(i + 2) % 6]; t.scale_z = edges[(i + 4) % 6];
         pending_transforms.push_back(t);
      end
      t = '0;
      t.quat_w = 32'sh0000_0001;
      t.scale_x = 32'sh7fff_ffff; t.scale_y = 32'sh8000_0000; t.scale_z = 32'sh7fff_ffff;
      pending_transforms.push_back(t);
      t.quat_w = 32'sh8000_0000; t.quat_x = 32'sh8000_0000;
      pending_transforms.push_back(t);
      t = '0;
      t.scale_x = 32'sh8000_0000; t.scale_y = 32'sh7fff_ffff; t.scale_z = 32'sh8000_0000;
      t.trans_x = 32'sh8000_0000; t.trans_y = 32'sh7fff_ffff; t.trans_z = -32'sd1;
      pending_transforms.push_back(t);
      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < 650; i++) begin
            t.trans_x = word_type'($urandom); t.trans_y = word_type'($urandom);
            t.trans_z = word_type'($urandom);
            t.quat_x = rand_word(); t.quat_y = rand_word();
            t.quat_z = rand_word(); t.quat_w = rand_word();
            if ($urandom_range(0, 19) == 0) t.quat_x = 0;
            if ($urandom_range(0, 29) == 0) begin
               t.quat_x = 0; t.quat_y = 0; t.quat_z = 0; t.quat_w = 0;
            end
            t.scale_x = rand_word(); t.scale_y = rand_word(); t.scale_z = rand_word();
            pending_transforms.push_back(t);
         end
         while (pending_transforms.size() > 0 || req_valid) @(posedge clock);
         if (phase == 0) begin
            idle_pct_req = 85; idle_pct_rsp = 13;
         end else begin
            idle_pct_req = 0; idle_pct_rsp = 0;
         end
      end
      while (expected_matrices.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Checked %0d transform beats against %0d matrix beats, %0d zero quaternions.",
               beats_in, beats_out, zero_quats);
      $display("Covered edge values, saturation and three idling patterns; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && expected_matrices.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
